// ===== src/dpb_pkg.sv =====
// Shared types, register codes and reset values for the depth pixel back-projection block.
`default_nettype none

package dpb_pkg;

	// Field widths fixed by the pixel and point formats.
	localparam int unsigned ColWidth   = 11;
	localparam int unsigned RowWidth   = 11;
	localparam int unsigned RawWidth   = 16;
	localparam int unsigned MaskWidth  = 8;
	localparam int unsigned ScaleWidth = 24;
	localparam int unsigned RangeWidth = 32;
	localparam int unsigned InvWidth   = 32;
	localparam int unsigned CentWidth  = 19;
	localparam int unsigned CoordWidth = 32;

	// Scaled depth is raw * Q0.24 >> 24, so it never exceeds the raw width.
	localparam int unsigned DepthWidth = RawWidth;
	// Magnitude of a Q.8 pixel offset.
	localparam int unsigned OffWidth   = CentWidth;
	// Offset magnitude times depth.
	localparam int unsigned MagWidth   = OffWidth + DepthWidth;

	localparam int unsigned CfgIdxWidth  = 4;
	localparam int unsigned CfgDataWidth = 32;

	localparam int DefMaxCols = 2048;
	localparam int DefMaxRows = 2048;

	localparam logic [MaskWidth-1:0] MaskExcluded = 8'hFF;

	// Register indexes of the configuration port.
	localparam logic [CfgIdxWidth-1:0] RegDepthScale = 4'd0;
	localparam logic [CfgIdxWidth-1:0] RegMinRange   = 4'd1;
	localparam logic [CfgIdxWidth-1:0] RegMaxRange   = 4'd2;
	localparam logic [CfgIdxWidth-1:0] RegInvFocalX  = 4'd3;
	localparam logic [CfgIdxWidth-1:0] RegInvFocalY  = 4'd4;
	localparam logic [CfgIdxWidth-1:0] RegCenterX    = 4'd5;
	localparam logic [CfgIdxWidth-1:0] RegCenterY    = 4'd6;
	localparam logic [CfgIdxWidth-1:0] RegMaskEnable = 4'd7;

	typedef struct packed {
		logic [ColWidth-1:0]  pixel_col;
		logic [RowWidth-1:0]  pixel_row;
		logic [RawWidth-1:0]  raw_depth;
		logic [MaskWidth-1:0] mask_byte;
	} pixel_t;

	typedef struct packed {
		logic [CoordWidth-1:0]        point_forward;
		logic signed [CoordWidth-1:0] point_left;
		logic signed [CoordWidth-1:0] point_up;
	} point_t;

	typedef struct packed {
		logic [ScaleWidth-1:0] depth_unit;
		logic [RangeWidth-1:0] min_range;
		logic [RangeWidth-1:0] max_range;
		logic [InvWidth-1:0]   inv_focal_x;
		logic [InvWidth-1:0]   inv_focal_y;
		logic [CentWidth-1:0]  center_x;
		logic [CentWidth-1:0]  center_y;
		logic                  mask_enable;
	} cfg_t;

	localparam cfg_t CfgReset = '{
		depth_unit:  24'd16777,
		min_range:   32'd0,
		max_range:   32'd655360,
		inv_focal_x: 32'd27962,
		inv_focal_y: 32'd27962,
		center_x:    19'd81920,
		center_y:    19'd61440,
		mask_enable: 1'b0
	};

	// Load enables of the four pipeline stages.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} pipe_en_t;

endpackage

`default_nettype wire

// ===== src/dpb_cfg.sv =====
// Configuration register file of the depth pixel back-projection block.
`default_nettype none

module dpb_cfg (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire  [dpb_pkg::CfgIdxWidth-1:0]      cfg_index,
	input  wire  [dpb_pkg::CfgDataWidth-1:0]     cfg_data,
	output dpb_pkg::cfg_t                        cfg
);

	dpb_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= dpb_pkg::CfgReset;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dpb_pkg::RegDepthScale: begin
					cfg_q.depth_unit <= cfg_data[dpb_pkg::ScaleWidth-1:0];
				end
				dpb_pkg::RegMinRange: begin
					cfg_q.min_range <= cfg_data[dpb_pkg::RangeWidth-1:0];
				end
				dpb_pkg::RegMaxRange: begin
					cfg_q.max_range <= cfg_data[dpb_pkg::RangeWidth-1:0];
				end
				dpb_pkg::RegInvFocalX: begin
					cfg_q.inv_focal_x <= cfg_data[dpb_pkg::InvWidth-1:0];
				end
				dpb_pkg::RegInvFocalY: begin
					cfg_q.inv_focal_y <= cfg_data[dpb_pkg::InvWidth-1:0];
				end
				dpb_pkg::RegCenterX: begin
					cfg_q.center_x <= cfg_data[dpb_pkg::CentWidth-1:0];
				end
				dpb_pkg::RegCenterY: begin
					cfg_q.center_y <= cfg_data[dpb_pkg::CentWidth-1:0];
				end
				dpb_pkg::RegMaskEnable: begin
					cfg_q.mask_enable <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== src/dpb_ctrl.sv =====
// Valid bits and load enables of the four-stage pipeline.
`default_nettype none

module dpb_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	input  wire                keep_in,
	input  wire                keep_s1,
	input  wire                out_stall,
	output logic               in_stall,
	output logic               out_valid,
	output dpb_pkg::pipe_en_t  en
);

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	// A stage may load when it is empty or its contents move on this cycle.
	assign rdy4 = !valid_s4 || !out_stall;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;

	assign in_stall  = !rdy1;
	assign out_valid = valid_s4;
	assign en        = '{s1: rdy1, s2: rdy2, s3: rdy3, s4: rdy4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			// Dropped pixels simply leave a bubble behind.
			if (rdy1) valid_s1 <= in_valid && keep_in;
			if (rdy2) valid_s2 <= valid_s1 && keep_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
		end
	end

endmodule

`default_nettype wire

// ===== src/dpb_lat.sv =====
// Lateral coordinate datapath for one axis: three multiplies, then sign and saturation.
`default_nettype none

module dpb_lat (
	input  wire                                   clk,
	input  wire dpb_pkg::pipe_en_t                en,
	input  wire  [dpb_pkg::OffWidth-1:0]          off_abs_s1,
	input  wire                                   off_neg_s1,
	input  wire  [dpb_pkg::DepthWidth-1:0]        depth_s1,
	input  wire  [dpb_pkg::InvWidth-1:0]          inv_focal,
	output logic signed [dpb_pkg::CoordWidth-1:0] coord_s4
);

	localparam int unsigned MagW  = dpb_pkg::MagWidth;
	localparam int unsigned InvW  = dpb_pkg::InvWidth;
	localparam int unsigned LoW   = 32;
	localparam int unsigned HiW   = MagW - LoW;
	localparam int unsigned HiPW  = HiW + InvW;
	localparam int unsigned LoPW  = LoW + InvW;
	localparam int unsigned SumW  = HiPW + 1;
	localparam int unsigned CW    = dpb_pkg::CoordWidth;

	localparam logic [SumW-1:0] PosLimit = SumW'({1'b0, {(CW-1){1'b1}}});
	localparam logic [SumW-1:0] NegLimit = SumW'({1'b1, {(CW-1){1'b0}}});

	logic [MagW-1:0] mag_s2;
	logic            neg_s2;
	logic [HiPW-1:0] prod_hi_s3;
	logic [LoPW-1:0] prod_lo_s3;
	logic            neg_s3;

	logic [SumW-1:0] q;
	logic [CW-1:0]   sat_pos;
	logic [CW-1:0]   sat_neg;
	logic [CW-1:0]   coord_next;

	// The Q.48 product splits into products of the high and low parts of the magnitude; the
	// sum below equals the full product shifted right by 32 exactly.
	always_comb begin
		q       = {1'b0, prod_hi_s3} + SumW'(prod_lo_s3[LoPW-1:LoW]);
		sat_pos = (q > PosLimit) ? PosLimit[CW-1:0] : q[CW-1:0];
		sat_neg = (q > NegLimit) ? NegLimit[CW-1:0] : q[CW-1:0];
		// A negative offset gives a positive coordinate, and the reverse.
		coord_next = neg_s3 ? sat_pos : (CW'(0) - sat_neg);
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			mag_s2 <= MagW'(off_abs_s1) * MagW'(depth_s1);
			neg_s2 <= off_neg_s1;
		end
		if (en.s3) begin
			prod_hi_s3 <= HiPW'(mag_s2[MagW-1:LoW]) * HiPW'(inv_focal);
			prod_lo_s3 <= LoPW'(mag_s2[LoW-1:0]) * LoPW'(inv_focal);
			neg_s3     <= neg_s2;
		end
		if (en.s4) begin
			coord_s4 <= coord_next;
		end
	end

endmodule

`default_nettype wire

// ===== src/depth_pixel_backprojection.sv =====
// Top level of the depth pixel back-projection block: pinhole camera, fixed point.
//
// Pixels arrive on the pixel channel (pixel_valid, pixel_stall, pixel) and points
// leave on the point channel (point_valid, point_stall, point). A transfer happens
// at a rising edge where valid is high and stall is low. Each pixel is scaled to
// metres and either dropped (masked, outside the image, or outside the depth range)
// or turned into one point of forward, left and up coordinates in Q16.16.
// The pipeline has four register stages. One pixel is accepted in every cycle while
// pixel_stall is low; the four stages come from giving the depth scaling, the
// offset-by-depth product and the product with the reciprocal focal length a stage
// each, then a final stage for combining the partial products, sign and saturation.
// Dropped pixels leave no point and cost nothing. When the receiver stalls, the
// stages fill up behind the held point and pixel_stall rises only once all four
// stages are occupied; nothing is lost. Reset empties the pipeline and returns every
// configuration register to its default. Registers are written through the cfg
// channel; the user must write them only while the block is idle, as the block
// itself does not enforce this.
`default_nettype none

module depth_pixel_backprojection #(
	parameter int MAX_COLS = dpb_pkg::DefMaxCols,
	parameter int MAX_ROWS = dpb_pkg::DefMaxRows
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  pixel_valid,
	output logic                                 pixel_stall,
	input  wire dpb_pkg::pixel_t                 pixel,
	output logic                                 point_valid,
	input  wire                                  point_stall,
	output dpb_pkg::point_t                      point,
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire  [dpb_pkg::CfgIdxWidth-1:0]      cfg_index,
	input  wire  [dpb_pkg::CfgDataWidth-1:0]     cfg_data
);

	localparam int unsigned ColW   = dpb_pkg::ColWidth;
	localparam int unsigned RowW   = dpb_pkg::RowWidth;
	localparam int unsigned DepthW = dpb_pkg::DepthWidth;
	localparam int unsigned ScaleW = dpb_pkg::ScaleWidth;
	localparam int unsigned ProdW  = dpb_pkg::RawWidth + ScaleW;
	localparam int unsigned OffW   = dpb_pkg::OffWidth;
	localparam int unsigned DiffW  = OffW + 1;
	localparam int unsigned LimW   = 14;
	localparam int unsigned RangeW = dpb_pkg::RangeWidth;
	localparam int unsigned CW     = dpb_pkg::CoordWidth;

	localparam logic [LimW-1:0] ColLimit = LimW'(MAX_COLS);
	localparam logic [LimW-1:0] RowLimit = LimW'(MAX_ROWS);

	dpb_pkg::cfg_t     cfg;
	dpb_pkg::pipe_en_t en;

	logic                keep_in;
	logic                keep_s1;
	logic [ProdW-1:0]    depth_prod;
	logic [DiffW-1:0]    diff_x, diff_y;
	logic [DiffW-1:0]    abs_x, abs_y;

	logic [DepthW-1:0]   depth_s1, depth_s2, depth_s3;
	logic [CW-1:0]       depth_s4;
	logic [OffW-1:0]     off_abs_x_s1, off_abs_y_s1;
	logic                off_neg_x_s1, off_neg_y_s1;
	logic signed [CW-1:0] left_s4, up_s4;

	dpb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Front stage: keep test on the pixel itself, depth scaling and pixel offsets.
	always_comb begin
		keep_in = ({{(LimW-ColW){1'b0}}, pixel.pixel_col} < ColLimit) &&
		          ({{(LimW-RowW){1'b0}}, pixel.pixel_row} < RowLimit) &&
		          !(cfg.mask_enable && (pixel.mask_byte == dpb_pkg::MaskExcluded));
		depth_prod = ProdW'(pixel.raw_depth) * ProdW'(cfg.depth_unit);
		// Offsets are the pixel position in Q.8 minus the principal point.
		diff_x = {1'b0, pixel.pixel_col, 8'b0} - {1'b0, cfg.center_x};
		diff_y = {1'b0, pixel.pixel_row, 8'b0} - {1'b0, cfg.center_y};
		abs_x  = diff_x[DiffW-1] ? (DiffW'(0) - diff_x) : diff_x;
		abs_y  = diff_y[DiffW-1] ? (DiffW'(0) - diff_y) : diff_y;
	end

	// The range test: strictly above the minimum, at most the maximum.
	assign keep_s1 = ({{(RangeW-DepthW){1'b0}}, depth_s1} > cfg.min_range) &&
	                 ({{(RangeW-DepthW){1'b0}}, depth_s1} <= cfg.max_range);

	always_ff @(posedge clk) begin
		if (en.s1) begin
			depth_s1     <= depth_prod[ProdW-1:ScaleW];
			off_abs_x_s1 <= abs_x[OffW-1:0];
			off_abs_y_s1 <= abs_y[OffW-1:0];
			off_neg_x_s1 <= diff_x[DiffW-1];
			off_neg_y_s1 <= diff_y[DiffW-1];
		end
		if (en.s2) depth_s2 <= depth_s1;
		if (en.s3) depth_s3 <= depth_s2;
		if (en.s4) depth_s4 <= CW'(depth_s3);
	end

	dpb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel_valid),
		.keep_in   (keep_in),
		.keep_s1   (keep_s1),
		.out_stall (point_stall),
		.in_stall  (pixel_stall),
		.out_valid (point_valid),
		.en        (en)
	);

	dpb_lat u_lat_x (
		.clk        (clk),
		.en         (en),
		.off_abs_s1 (off_abs_x_s1),
		.off_neg_s1 (off_neg_x_s1),
		.depth_s1   (depth_s1),
		.inv_focal  (cfg.inv_focal_x),
		.coord_s4   (left_s4)
	);

	dpb_lat u_lat_y (
		.clk        (clk),
		.en         (en),
		.off_abs_s1 (off_abs_y_s1),
		.off_neg_s1 (off_neg_y_s1),
		.depth_s1   (depth_s1),
		.inv_focal  (cfg.inv_focal_y),
		.coord_s4   (up_s4)
	);

	assign point = '{point_forward: depth_s4, point_left: left_s4, point_up: up_s4};

endmodule

`default_nettype wire

// ===== src/dpb_chk.sv =====
// Port-level checker for the depth pixel back-projection block, with its bind.
`default_nettype none

module dpb_chk (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  pixel_stall,
	input wire                  point_valid,
	input wire                  point_stall,
	input wire dpb_pkg::point_t point
);

	// A held point stays put until it is taken.
	a_point_hold: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && point_stall |=> point_valid && $stable(point))
		else $error("point changed or vanished while stalled");

	// The input only backs up when the whole pipeline is full behind a stalled point.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |-> point_valid && point_stall)
		else $error("pixel channel stalled without a stalled point");

	// Depths at or below the minimum are dropped, so a point never has zero depth.
	a_depth_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid |-> point.point_forward != 32'd0)
		else $error("point emitted with zero depth");

	// Scaled depth never exceeds the raw sample, so its top half is clear.
	a_depth_width: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid |-> point.point_forward[31:16] == 16'd0)
		else $error("point depth wider than the raw sample allows");

endmodule

bind depth_pixel_backprojection dpb_chk u_dpb_chk (.*);

`default_nettype wire

// ===== verif/depth_pixel_backprojection_tb.sv =====
// Self-checking testbench for the depth pixel back-projection block with its own point predictor.
module depth_pixel_backprojection_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// The block is built with its default image size, so the predictor uses the same bounds.
	localparam int ImageCols = dpb_pkg::DefMaxCols;
	localparam int ImageRows = dpb_pkg::DefMaxRows;
	// Highest index the configuration port can carry; anything above RegMaskEnable is unused.
	localparam int RegLimit = (1 << dpb_pkg::CfgIdxWidth) - 1;
	// Saturation limits of a signed Q16.16 coordinate, as magnitudes.
	localparam logic [51:0] CoordPosMax = 52'h7FFF_FFFF;
	localparam logic [51:0] CoordNegMax = 52'h8000_0000;

	typedef enum logic [1:0] {
		STALL_NEVER,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_e;

	logic clk;
	logic arst_n = 1'b0;

	logic pixel_valid = 1'b0;
	logic pixel_stall;
	dpb_pkg::pixel_t pixel = '0;
	logic point_valid;
	logic point_stall = 1'b0;
	dpb_pkg::point_t point;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [dpb_pkg::CfgIdxWidth-1:0] cfg_index = '0;
	logic [dpb_pkg::CfgDataWidth-1:0] cfg_data = '0;

	// Pixels waiting to be offered, and the points that accepted pixels must produce, in order.
	dpb_pkg::pixel_t pending_pixels[$];
	dpb_pkg::point_t pending_points[$];
	// The testbench's own copy of the configuration registers.
	dpb_pkg::cfg_t live_cfg = dpb_pkg::CfgReset;

	// Sender burst shaping and the hold used to drain the pipeline in the middle of a phase.
	int burst_left = 0;
	int gap_left = 0;
	bit drain_hold = 1'b0;

	// Receiver stall pattern.
	stall_mode_e stall_mode = STALL_NEVER;
	int mode_left = 0;
	int stall_tick = 0;

	int pixels_sent = 0;
	int pixels_dropped = 0;
	int points_checked = 0;
	int error_count = 0;
	int settings_run = 0;
	dpb_pkg::point_t next_point;

	depth_pixel_backprojection uut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel(pixel),
		.point_valid(point_valid),
		.point_stall(point_stall),
		.point(point),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// A generous ceiling: the slowest legal run needs only a small fraction of this.
	initial begin
		#1_000_000;
		$display("tb: failure");
		$finish;
	end

	// Lateral coordinate of one axis: the pixel offset from the principal point (Q.8) times
	// the depth (Q16.16) times the reciprocal focal length (Q8.24), kept exact and then cut
	// back to Q16.16 by dropping 32 fraction bits of the magnitude. The sign is the opposite
	// of the offset, and the result saturates to the signed 32-bit range.
	function automatic logic [31:0] lateral_coord(logic [dpb_pkg::ColWidth-1:0] pos,
			logic [dpb_pkg::CentWidth-1:0] centre, logic [31:0] depth, logic [31:0] inv);
		int off;
		logic [19:0] off_mag;
		logic [83:0] full;
		logic [51:0] mag;
		off = int'(pos) * 256 - int'(centre);
		off_mag = 20'((off < 0) ? -off : off);
		full = off_mag * depth * inv;
		mag = 52'(full >> 32);
		if (mag == '0)
			return '0;
		// A pixel left of the centre gives a positive left coordinate, and likewise for up.
		if (off < 0)
			return (mag > CoordPosMax) ? CoordPosMax[31:0] : mag[31:0];
		return (mag > CoordNegMax) ? CoordNegMax[31:0] : 32'd0 - mag[31:0];
	endfunction

	// Works out the point a pixel produces under the given settings; returns 0 if dropped.
	function automatic bit project_pixel(input dpb_pkg::pixel_t px, input dpb_pkg::cfg_t c,
			output dpb_pkg::point_t pt);
		logic [39:0] scaled;
		logic [31:0] depth;
		scaled = px.raw_depth * c.depth_unit;
		depth = 32'(scaled >> 24);
		pt = '0;
		// Pixels outside the image are dropped; with 11-bit indexes and the default size this
		// cannot happen, but the check is kept so that the predictor follows the block's rules.
		if (int'(px.pixel_col) >= ImageCols || int'(px.pixel_row) >= ImageRows)
			return 1'b0;
		if (c.mask_enable && px.mask_byte == dpb_pkg::MaskExcluded)
			return 1'b0;
		// The lower bound is exclusive and the upper inclusive, so a zero scale or an empty
		// range drops everything.
		if (depth <= c.min_range || depth > c.max_range)
			return 1'b0;
		pt.point_forward = depth;
		pt.point_left = lateral_coord(px.pixel_col, c.center_x, depth, c.inv_focal_x);
		pt.point_up = lateral_coord(px.pixel_row, c.center_y, depth, c.inv_focal_y);
		return 1'b1;
	endfunction

	// Called for every pixel transfer: record the point it must produce, if any.
	function automatic void log_expectation(dpb_pkg::pixel_t px);
		dpb_pkg::point_t pt;
		pixels_sent++;
		if (project_pixel(px, live_cfg, pt))
			pending_points = {pending_points, pt};
		else
			pixels_dropped++;
	endfunction

	// Mirrors a register write into the predictor's settings; narrow registers keep only
	// their low bits and unused indexes are ignored.
	function automatic void store_register(logic [dpb_pkg::CfgIdxWidth-1:0] idx,
			logic [dpb_pkg::CfgDataWidth-1:0] data);
		case (idx)
			dpb_pkg::RegDepthScale: live_cfg.depth_unit = data[dpb_pkg::ScaleWidth-1:0];
			dpb_pkg::RegMinRange:   live_cfg.min_range = data[dpb_pkg::RangeWidth-1:0];
			dpb_pkg::RegMaxRange:   live_cfg.max_range = data[dpb_pkg::RangeWidth-1:0];
			dpb_pkg::RegInvFocalX:  live_cfg.inv_focal_x = data[dpb_pkg::InvWidth-1:0];
			dpb_pkg::RegInvFocalY:  live_cfg.inv_focal_y = data[dpb_pkg::InvWidth-1:0];
			dpb_pkg::RegCenterX:    live_cfg.center_x = data[dpb_pkg::CentWidth-1:0];
			dpb_pkg::RegCenterY:    live_cfg.center_y = data[dpb_pkg::CentWidth-1:0];
			dpb_pkg::RegMaskEnable: live_cfg.mask_enable = data[0];
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at %0t ns: %s", $time, what);
		error_count++;
	endtask

	function automatic dpb_pkg::pixel_t make_pixel(int col, int row, int raw, int mb);
		dpb_pkg::pixel_t px;
		px.pixel_col = dpb_pkg::ColWidth'(col);
		px.pixel_row = dpb_pkg::RowWidth'(row);
		px.raw_depth = dpb_pkg::RawWidth'(raw);
		px.mask_byte = dpb_pkg::MaskWidth'(mb);
		return px;
	endfunction

	// Random pixels lean towards the edges of the image, the ends of the depth range and the
	// excluded mask value, while still covering every bit of every field.
	function automatic dpb_pkg::pixel_t random_pixel();
		dpb_pkg::pixel_t px;
		px.pixel_col = ($urandom_range(0, 7) == 0)
			? {dpb_pkg::ColWidth{$urandom_range(0, 1) == 1}}
			: dpb_pkg::ColWidth'($urandom);
		px.pixel_row = ($urandom_range(0, 7) == 0)
			? {dpb_pkg::RowWidth{$urandom_range(0, 1) == 1}}
			: dpb_pkg::RowWidth'($urandom);
		case ($urandom_range(0, 7))
			0: px.raw_depth = {dpb_pkg::RawWidth{$urandom_range(0, 1) == 1}};
			1: px.raw_depth = dpb_pkg::RawWidth'($urandom_range(1, 64));
			default: px.raw_depth = dpb_pkg::RawWidth'($urandom);
		endcase
		case ($urandom_range(0, 7))
			0, 1: px.mask_byte = dpb_pkg::MaskExcluded;
			2: px.mask_byte = dpb_pkg::MaskExcluded - 8'd1;
			default: px.mask_byte = dpb_pkg::MaskWidth'($urandom);
		endcase
		return px;
	endfunction

	// Plausible camera settings with the occasional extreme; the depth window is placed
	// inside what the chosen scale can reach so that most pixels give a point.
	function automatic dpb_pkg::cfg_t random_settings();
		dpb_pkg::cfg_t c;
		int reach;
		int lo;
		c.depth_unit = ($urandom_range(0, 2) == 0)
			? dpb_pkg::ScaleWidth'($urandom_range(1, 24'hFFFFFF))
			: dpb_pkg::ScaleWidth'($urandom_range(1000, 300000));
		reach = int'((64'd65535 * c.depth_unit) >> 24);
		lo = $urandom_range(0, reach / 3);
		c.min_range = lo;
		c.max_range = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF
			: 32'($urandom_range(lo + 1, reach + reach / 4 + 1));
		c.inv_focal_x = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(8389, 83886);
		c.inv_focal_y = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(8389, 83886);
		c.center_x = dpb_pkg::CentWidth'($urandom_range(0, 524287));
		c.center_y = dpb_pkg::CentWidth'($urandom_range(0, 524287));
		c.mask_enable = 1'($urandom_range(0, 1));
		return c;
	endfunction

	// Pixel sender. Pixels come from the pending queue in bursts of random length separated
	// by random gaps; some bursts are long and gap-free. A pixel is held unchanged while the
	// block stalls it, and the expected point is logged at the edge of its transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_valid <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (pixel_valid && !pixel_stall)
				log_expectation(pixel);
			if (!pixel_valid || !pixel_stall) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					pixel_valid <= 1'b0;
				end else if (pending_pixels.size() != 0 && !drain_hold) begin
					pixel <= pending_pixels.pop_front();
					pixel_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= ($urandom_range(0, 5) == 0) ? $urandom_range(100, 250)
							: $urandom_range(1, 24);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					pixel_valid <= 1'b0;
				end
			end
		end
	end

	// Point receiver. Every transfer is compared field by field with the oldest expected
	// point. The stall line follows a pattern of its own that switches now and then between
	// never stalling, light and heavy random stalling, and a fixed periodic pattern.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_stall <= 1'b0;
			stall_mode <= STALL_NEVER;
			mode_left <= 0;
		end else begin
			if (point_valid && !point_stall) begin
				if (pending_points.size() == 0) begin
					report_mismatch($sformatf("point %h/%h/%h with no pixel behind it",
						point.point_forward, point.point_left, point.point_up));
				end else begin
					next_point = pending_points.pop_front();
					points_checked++;
					if (point.point_forward !== next_point.point_forward)
						report_mismatch($sformatf("forward %h, expected %h",
							point.point_forward, next_point.point_forward));
					if (point.point_left !== next_point.point_left)
						report_mismatch($sformatf("left %h, expected %h",
							point.point_left, next_point.point_left));
					if (point.point_up !== next_point.point_up)
						report_mismatch($sformatf("up %h, expected %h",
							point.point_up, next_point.point_up));
				end
			end
			if (mode_left == 0) begin
				stall_mode <= stall_mode_e'($urandom_range(0, 3));
				mode_left <= $urandom_range(20, 200);
			end else begin
				mode_left <= mode_left - 1;
			end
			stall_tick <= stall_tick + 1;
			case (stall_mode)
				STALL_NEVER:    point_stall <= 1'b0;
				STALL_LIGHT:    point_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY:    point_stall <= ($urandom_range(0, 3) != 0);
				STALL_PERIODIC: point_stall <= (stall_tick % 7) < 3;
				default:        point_stall <= 1'b0;
			endcase
		end
	end

	// One register write on the configuration channel; the predictor's copy is updated at
	// the transfer.
	task automatic write_reg(logic [dpb_pkg::CfgIdxWidth-1:0] idx,
			logic [dpb_pkg::CfgDataWidth-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		store_register(idx, data);
	endtask

	// Writes every register, with junk above the narrow ones, and pokes one unused index.
	task automatic apply_settings(dpb_pkg::cfg_t c);
		logic [31:0] junk;
		junk = $urandom;
		write_reg(dpb_pkg::RegDepthScale, {junk[31:24], c.depth_unit});
		write_reg(dpb_pkg::RegMinRange, c.min_range);
		write_reg(dpb_pkg::RegMaxRange, c.max_range);
		write_reg(dpb_pkg::RegInvFocalX, c.inv_focal_x);
		write_reg(dpb_pkg::RegInvFocalY, c.inv_focal_y);
		write_reg(dpb_pkg::RegCenterX, {junk[31:19], c.center_x});
		write_reg(dpb_pkg::RegCenterY, {junk[12:0], c.center_y});
		write_reg(dpb_pkg::RegMaskEnable, {junk[30:0], c.mask_enable});
		write_reg(dpb_pkg::CfgIdxWidth'($urandom_range(int'(dpb_pkg::RegMaskEnable) + 1,
			RegLimit)), $urandom);
		settings_run++;
		@(negedge clk);
	endtask

	// Waits until every pixel has been transferred and every expected point has arrived, then
	// lets the four pipeline stages run dry in case a dropped pixel is still passing through.
	task automatic wait_idle();
		@(negedge clk);
		while (pending_pixels.size() != 0 || pixel_valid || pending_points.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Queues a batch of random pixels. With hold_midway set, the sender stops half way and
	// resumes only once the pipeline has delivered every outstanding point.
	task automatic run_random(int count, bit hold_midway);
		for (int i = 0; i < count; i++)
			pending_pixels = {pending_pixels, random_pixel()};
		if (hold_midway) begin
			while (pending_pixels.size() > count / 2)
				@(negedge clk);
			drain_hold = 1'b1;
			while (pixel_valid || pending_points.size() != 0)
				@(negedge clk);
			drain_hold = 1'b0;
		end
		wait_idle();
	endtask

	initial begin
		dpb_pkg::cfg_t c;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: image corners, the centre pixel, zero and full-scale depth, and an
		// excluded mask byte that must pass because masking is still off.
		pending_pixels = {pending_pixels, make_pixel(0, 0, 1000, 0)};
		pending_pixels = {pending_pixels, make_pixel(2047, 2047, 1000, 255)};
		pending_pixels = {pending_pixels, make_pixel(0, 2047, 65535, 0)};
		pending_pixels = {pending_pixels, make_pixel(2047, 0, 0, 0)};
		pending_pixels = {pending_pixels, make_pixel(320, 240, 5000, 17)};
		pending_pixels = {pending_pixels, make_pixel(1023, 1024, 9999, 170)};
		pending_pixels = {pending_pixels, make_pixel(1, 1, 1, 85)};
		pending_pixels = {pending_pixels, make_pixel(2047, 2047, 65535, 254)};
		wait_idle();

		// Everything at its extreme: full scale and focal terms push the lateral coordinates
		// into saturation on both sides, and masking is switched on.
		c.depth_unit = '1;
		c.min_range = '0;
		c.max_range = '1;
		c.inv_focal_x = '1;
		c.inv_focal_y = '1;
		c.center_x = '0;
		c.center_y = '1;
		c.mask_enable = 1'b1;
		apply_settings(c);
		pending_pixels = {pending_pixels, make_pixel(2047, 0, 65535, 254)};
		pending_pixels = {pending_pixels, make_pixel(0, 2047, 65535, 255)};
		pending_pixels = {pending_pixels, make_pixel(0, 0, 65535, 0)};
		pending_pixels = {pending_pixels, make_pixel(2047, 2047, 1, 1)};
		pending_pixels = {pending_pixels, make_pixel(2047, 2047, 2, 0)};
		pending_pixels = {pending_pixels, make_pixel(1024, 1024, 300, 0)};
		wait_idle();
		run_random(100, 1'b1);

		// A scale of 1/256 makes the depth the raw sample shifted down by eight, so the
		// pixels below sit just either side of both depth bounds.
		c = dpb_pkg::CfgReset;
		c.depth_unit = 24'h01_0000;
		c.min_range = 100;
		c.max_range = 200;
		apply_settings(c);
		pending_pixels = {pending_pixels, make_pixel(700, 500, 25855, 3)};
		pending_pixels = {pending_pixels, make_pixel(700, 500, 25856, 3)};
		pending_pixels = {pending_pixels, make_pixel(10, 1900, 51455, 3)};
		pending_pixels = {pending_pixels, make_pixel(10, 1900, 51456, 3)};
		wait_idle();
		run_random(60, 1'b0);

		// Zero scale: every depth is zero and nothing may come out.
		c = random_settings();
		c.depth_unit = '0;
		apply_settings(c);
		run_random(80, 1'b0);

		// Empty depth window: the lower bound equals the upper one.
		c = random_settings();
		c.max_range = c.min_range;
		apply_settings(c);
		run_random(80, 1'b0);

		// Zero reciprocal focal lengths flatten both lateral coordinates to zero.
		c = random_settings();
		c.inv_focal_x = '0;
		c.inv_focal_y = '0;
		apply_settings(c);
		run_random(80, 1'b0);

		for (int k = 0; k < 7; k++) begin
			apply_settings(random_settings());
			run_random(110, k == 3);
		end

		$display("summary: %0d pixels transferred under %0d register settings, %0d dropped",
			pixels_sent, settings_run + 1, pixels_dropped);
		$display("summary: %0d points checked, %0d mismatches", points_checked, error_count);
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== files.f =====
src/dpb_pkg.sv
src/dpb_cfg.sv
src/dpb_ctrl.sv
src/dpb_lat.sv
src/depth_pixel_backprojection.sv
src/dpb_chk.sv
verif/depth_pixel_backprojection_tb.sv
